// ----- hdl/assert_macros.svh -----
// ---------------------------------------------------------------------------
// assert_macros.svh
// clocked assertion helpers shared by the sort core
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge outside reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// expression that must never hold
`define ASSERT_NEVER(label, expr, msg) \
  `ASSERT_CLK(label, !(expr), msg)

`endif

// ----- hdl/bsoc_pkg.sv -----
// ---------------------------------------------------------------------------
// bsoc_pkg
// shared widths, defaults and the store access type of the sort core
// ---------------------------------------------------------------------------
package bsoc_pkg;

  localparam int DEPTH_DEF = 64;
  localparam int DATA_W    = 32;
  localparam int ADDR_W    = 6;
  localparam int FILL_W    = 7;
  localparam int CNT_W     = 11;

  // one store access per cycle: one write and one read
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [DATA_W-1:0] wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

endpackage

// ----- hdl/bubble_sort_with_op_counts_core.sv -----
// ---------------------------------------------------------------------------
// bubble_sort_with_op_counts_core
// loads a set of signed values, bubble sorts it in place in the element
// store and emits it in order with comparison and swap totals
// ---------------------------------------------------------------------------
//  channel  dir  payload                                   handshake
//  in_      in   tdata value, tlast last_item              tvalid/tready
//  out_     out  tdata value/position/counts, tuser ovf,   tvalid/tready
//                tlast last_result
//
// load takes one item per cycle; the sort does a single read and a
// single write of the store per compare, with priming reads ahead of
// each pass; emit reads each result from the store, registers it and
// holds it until out_tready takes it, so results do not go back to back.
// in_tready is high only while loading; an out_tready stall holds the
// sequencer. reset clears the counters and fill state, no store sweep.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module bubble_sort_with_op_counts_core
  import bsoc_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] value
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // [31:0] sorted_value, [37:32] position,
                                  // [48:38] compare_count, [59:49] swap_count
  output logic        out_tuser,  // [0] overflow
  output logic        out_tlast
);

  mem_req_t          mem_req;
  logic [DATA_W-1:0] mem_rdata;
  logic [DATA_W-1:0] out_value;
  logic [ADDR_W-1:0] out_pos;
  logic [CNT_W-1:0]  out_cmp;
  logic [CNT_W-1:0]  out_swp;
  logic              out_done;
  logic              same_entry;

  // sequencer
  bsoc_ctrl #(
    .DEPTH(DEPTH)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_value (out_value),
    .out_pos   (out_pos),
    .out_cmp   (out_cmp),
    .out_swp   (out_swp),
    .out_ovf   (out_tuser),
    .out_tlast (out_tlast),
    .mem_req   (mem_req),
    .mem_rdata (mem_rdata)
  );

  // element store
  bsoc_ram #(
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .req  (mem_req),
    .rdata(mem_rdata)
  );

  // result packing
  assign out_tdata = {4'b0000, out_swp, out_cmp, out_pos, out_value};

  // check helpers
  assign out_done   = out_tvalid && out_tready && out_tlast;
  assign same_entry = mem_req.we && mem_req.re && (mem_req.waddr == mem_req.raddr);

  // checks
  `ASSERT_NEVER(a_load_emit_apart, in_tready && out_tvalid, "load and emit overlap")
  `ASSERT_CLK(a_back_to_load, out_done |=> in_tready, "no return to load after last result")
  `ASSERT_NEVER(a_no_rw_clash, same_entry, "store read and write hit one entry")

endmodule

// ----- hdl/bsoc_ram.sv -----
// ---------------------------------------------------------------------------
// bsoc_ram
// element store, one write and one read port, registered read data
// ---------------------------------------------------------------------------
module bsoc_ram
  import bsoc_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic              clk,
  input  mem_req_t          req,
  output logic [DATA_W-1:0] rdata
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [DATA_W-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr[AW-1:0]] <= req.wdata;
    end
    if (req.re) begin
      rdata <= mem[req.raddr[AW-1:0]];
    end
  end

endmodule

// ----- hdl/bsoc_ctrl.sv -----
// ---------------------------------------------------------------------------
// bsoc_ctrl
// load, bubble sort passes and emit sequencer around the element store
// ---------------------------------------------------------------------------
module bsoc_ctrl
  import bsoc_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [DATA_W-1:0] in_tdata,
  input  logic              in_tlast,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [DATA_W-1:0] out_value,
  output logic [ADDR_W-1:0] out_pos,
  output logic [CNT_W-1:0]  out_cmp,
  output logic [CNT_W-1:0]  out_swp,
  output logic              out_ovf,
  output logic              out_tlast,
  output mem_req_t          mem_req,
  input  logic [DATA_W-1:0] mem_rdata
);

  typedef enum logic [2:0] {
    S_LOAD, S_START, S_PRIME, S_RUN, S_PEND, S_ERD, S_ELD, S_EWAIT
  } state_t;

  state_t            state_r;
  logic [FILL_W-1:0] fill_r;
  logic              ovf_r;
  logic [FILL_W-1:0] len_r;
  logic [ADDR_W-1:0] idx_r;
  logic [ADDR_W-1:0] eidx_r;
  logic [DATA_W-1:0] carry_r;
  logic [CNT_W-1:0]  cmp_r;
  logic [CNT_W-1:0]  swp_r;

  logic [FILL_W-1:0] len_m1;
  logic              has_room;
  logic              gt;
  logic              pass_done;
  logic              emit_last;

  assign len_m1    = len_r - FILL_W'(1);
  assign has_room  = fill_r < FILL_W'(DEPTH);
  assign gt        = $signed(carry_r) > $signed(mem_rdata);
  assign pass_done = {1'b0, idx_r} == len_m1;
  assign emit_last = {1'b0, eidx_r} == (fill_r - FILL_W'(1));
  assign in_tready = state_r == S_LOAD;

  // store access selection
  always_comb begin
    mem_req       = '0;
    mem_req.wdata = carry_r;
    case (state_r)
      S_LOAD: begin
        mem_req.we    = in_tvalid && has_room;
        mem_req.waddr = fill_r[ADDR_W-1:0];
        mem_req.wdata = in_tdata;
      end
      S_START: begin
        mem_req.re = fill_r >= FILL_W'(2);
      end
      S_PRIME: begin
        mem_req.re    = 1'b1;
        mem_req.raddr = ADDR_W'(1);
      end
      S_RUN: begin
        // smaller of the pair settles left, larger rides on in carry
        mem_req.we    = 1'b1;
        mem_req.waddr = idx_r - ADDR_W'(1);
        mem_req.wdata = gt ? mem_rdata : carry_r;
        mem_req.re    = !pass_done;
        mem_req.raddr = idx_r + ADDR_W'(1);
      end
      S_PEND: begin
        // largest of the pass lands at its end, next pass starts reading
        mem_req.we    = 1'b1;
        mem_req.waddr = len_m1[ADDR_W-1:0];
        mem_req.re    = len_m1 >= FILL_W'(2);
      end
      S_ERD: begin
        mem_req.re    = 1'b1;
        mem_req.raddr = eidx_r;
      end
      S_EWAIT: begin
        mem_req.re    = out_tready && !out_tlast;
        mem_req.raddr = eidx_r + ADDR_W'(1);
      end
      default: begin
        mem_req.re = 1'b0;
      end
    endcase
  end

  // sequencer state, counters and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_LOAD;
      fill_r     <= '0;
      ovf_r      <= 1'b0;
      cmp_r      <= '0;
      swp_r      <= '0;
      out_tvalid <= 1'b0;
    end else begin
      case (state_r)
        S_LOAD: begin
          if (in_tvalid) begin
            if (has_room) begin
              fill_r <= fill_r + FILL_W'(1);
            end else begin
              ovf_r <= 1'b1;
            end
            if (in_tlast) begin
              state_r <= S_START;
            end
          end
        end
        S_START: begin
          cmp_r  <= '0;
          swp_r  <= '0;
          len_r  <= fill_r;
          eidx_r <= '0;
          state_r <= (fill_r >= FILL_W'(2)) ? S_PRIME : S_ERD;
        end
        S_PRIME: begin
          carry_r <= mem_rdata;
          idx_r   <= ADDR_W'(1);
          state_r <= S_RUN;
        end
        S_RUN: begin
          cmp_r <= cmp_r + CNT_W'(1);
          if (gt) begin
            swp_r <= swp_r + CNT_W'(1);
          end else begin
            carry_r <= mem_rdata;
          end
          if (pass_done) begin
            state_r <= S_PEND;
          end else begin
            idx_r <= idx_r + ADDR_W'(1);
          end
        end
        S_PEND: begin
          len_r   <= len_m1;
          state_r <= (len_m1 >= FILL_W'(2)) ? S_PRIME : S_ERD;
        end
        S_ERD: begin
          state_r <= S_ELD;
        end
        S_ELD: begin
          out_tvalid <= 1'b1;
          out_value  <= mem_rdata;
          out_pos    <= eidx_r;
          out_cmp    <= cmp_r;
          out_swp    <= swp_r;
          out_ovf    <= ovf_r;
          out_tlast  <= emit_last;
          state_r    <= S_EWAIT;
        end
        S_EWAIT: begin
          if (out_tready) begin
            out_tvalid <= 1'b0;
            if (out_tlast) begin
              fill_r  <= '0;
              ovf_r   <= 1'b0;
              state_r <= S_LOAD;
            end else begin
              eidx_r  <= eidx_r + ADDR_W'(1);
              state_r <= S_ELD;
            end
          end
        end
        default: begin
          state_r <= S_LOAD;
        end
      endcase
    end
  end

endmodule

// ----- tb/tb_bubble_sort_with_op_counts_core.sv -----
// ---------------------------------------------------------------------------
// tb_bubble_sort_with_op_counts_core
// sets of signed items go in on the in_ stream and come back sorted on the
// out_ stream; a scoreboard keeps its own bubble sort of every set and
// checks each sorted item, its position, both op counts and the flags
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_bubble_sort_with_op_counts_core
  import bsoc_pkg::*;
;

  localparam int STORE_DEPTH = DEPTH_DEF;
  localparam int RAND_ITEMS  = 300;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_WAIT  = 40;

  typedef enum int {MODE_WIDE, MODE_NARROW, MODE_EDGE} value_mode_t;

  // one sorted item as it should leave the block
  typedef struct {
    logic signed [DATA_W-1:0] value;
    logic [ADDR_W-1:0]        position;
    logic [CNT_W-1:0]         compares;
    logic [CNT_W-1:0]         swaps;
    logic                     overflow;
    logic                     last;
  } sorted_item_t;

  // collects each set, sorts it and holds the sorted items still to come
  class sort_scoreboard;
    logic signed [DATA_W-1:0] set_values[$];
    bit                       set_dropped;
    sorted_item_t             sorted_pending[$];
    int                       mismatches;

    task report(string what, logic [63:0] got, logic [63:0] want);
      $display("%0t mismatch %s: got %0h want %0h", $realtime, what, got, want);
      mismatches++;
    endtask

    function int pending();
      return sorted_pending.size();
    endfunction

    // store the item; on the closing item bubble sort the set
    function void note_input(logic [DATA_W-1:0] v, logic l);
      logic signed [DATA_W-1:0] work[STORE_DEPTH];
      logic signed [DATA_W-1:0] hold;
      logic [CNT_W-1:0]         cmp_cnt;
      logic [CNT_W-1:0]         swp_cnt;
      sorted_item_t             item;
      int                       n;
      if (set_values.size() < STORE_DEPTH) set_values.push_back(v);
      else set_dropped = 1'b1;
      if (!l) return;
      n = set_values.size();
      for (int k = 0; k < n; k++) work[k] = set_values[k];
      cmp_cnt = '0;
      swp_cnt = '0;
      // full passes over a shrinking prefix, no early exit
      for (int len = n; len > 0; len--) begin
        for (int k = 0; k + 1 < len; k++) begin
          cmp_cnt++;
          if (work[k] > work[k+1]) begin
            hold      = work[k];
            work[k]   = work[k+1];
            work[k+1] = hold;
            swp_cnt++;
          end
        end
      end
      for (int k = 0; k < n; k++) begin
        item.value    = work[k];
        item.position = k[ADDR_W-1:0];
        item.compares = cmp_cnt;
        item.swaps    = swp_cnt;
        item.overflow = set_dropped;
        item.last     = (k == n - 1);
        sorted_pending.push_back(item);
      end
      set_values.delete();
      set_dropped = 1'b0;
    endfunction

    task check_result(logic [63:0] d, logic u, logic l);
      sorted_item_t want;
      if (sorted_pending.size() == 0) begin
        report("unexpected item", d, 0);
        return;
      end
      want = sorted_pending.pop_front();
      if (d[31:0] !== want.value) report("sorted_value", d[31:0], want.value);
      if (d[37:32] !== want.position) report("position", d[37:32], want.position);
      if (d[48:38] !== want.compares) report("compare_count", d[48:38], want.compares);
      if (d[59:49] !== want.swaps) report("swap_count", d[59:49], want.swaps);
      if (u !== want.overflow) report("overflow", u, want.overflow);
      if (l !== want.last) report("last_result", l, want.last);
    endtask
  endclass

  logic              clk;
  logic              rst_n;
  logic              in_tvalid;
  logic              in_tready;
  logic [31:0]       in_tdata;   // [31:0] value
  logic              in_tlast;
  logic              out_tvalid;
  logic              out_tready;
  logic [63:0]       out_tdata;  // [31:0] sorted_value, [37:32] position,
                                 // [48:38] compare_count, [59:49] swap_count
  logic              out_tuser;  // [0] overflow
  logic              out_tlast;

  sort_scoreboard sb;
  bit             no_idle;
  int             cycle_count;

  bubble_sort_with_op_counts_core uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // sorted item sink with random back-pressure
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) sb.check_result(out_tdata, out_tuser, out_tlast);
      out_tready <= no_idle ? 1'b1 : ($urandom_range(99) >= 33);
    end
  end

  // cycle limit
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  // one item on the input stream, random idle cycles ahead of it
  task automatic send_item(input logic [DATA_W-1:0] v, input logic l);
    while (!no_idle && $urandom_range(99) < 33) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= v;
    in_tlast  <= l;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_input(v, l);
  endtask

  function automatic logic [DATA_W-1:0] pick_value(value_mode_t mode);
    case (mode)
      MODE_WIDE:   return $urandom;
      // narrow range gives many equal neighbors
      MODE_NARROW: return 32'($urandom_range(8)) - 32'd4;
      default: begin
        case ($urandom_range(4))
          0:       return 32'h8000_0000;
          1:       return 32'h7FFF_FFFF;
          2:       return 32'hFFFF_FFFF;
          3:       return 32'h0000_0000;
          default: return $urandom;
        endcase
      end
    endcase
  endfunction

  initial begin
    int          rand_sent;
    int          set_count;
    int          set_len;
    int          roll;
    value_mode_t mode;

    sb = new();
    no_idle    = 1'b0;
    rst_n      <= 1'b0;
    in_tvalid  <= 1'b0;
    in_tdata   <= '0;
    in_tlast   <= 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // single item sets at both extremes
    send_item(32'h7FFF_FFFF, 1'b1);
    send_item(32'h8000_0000, 1'b1);
    // two items, one swap
    send_item(32'h7FFF_FFFF, 1'b0);
    send_item(32'h8000_0000, 1'b1);
    // already sorted, no swaps
    send_item(32'hFFFF_FFFE, 1'b0);
    send_item(32'hFFFF_FFFF, 1'b0);
    send_item(32'h0000_0000, 1'b0);
    send_item(32'h0000_0001, 1'b1);
    // reversed, every compare swaps
    send_item(32'h7FFF_FFFF, 1'b0);
    send_item(32'h0000_0001, 1'b0);
    send_item(32'h0000_0000, 1'b0);
    send_item(32'hFFFF_FFFF, 1'b0);
    send_item(32'h8000_0000, 1'b1);
    // duplicates around a negative value
    send_item(32'd5, 1'b0);
    send_item(32'd5, 1'b0);
    send_item(32'hFFFF_FFFB, 1'b0);
    send_item(32'd5, 1'b1);
    // all equal
    send_item(32'h0, 1'b0);
    send_item(32'h0, 1'b0);
    send_item(32'h0, 1'b1);

    // random sets: first an overflowing one, then a full one, mostly short
    rand_sent = 0;
    set_count = 0;
    while (rand_sent < RAND_ITEMS) begin
      roll = $urandom_range(99);
      if (set_count == 0) set_len = STORE_DEPTH + 1;
      else if (set_count == 1) set_len = STORE_DEPTH;
      else if (roll < 3) set_len = $urandom_range(STORE_DEPTH + 6, STORE_DEPTH - 3);
      else if (roll < 13) set_len = $urandom_range(40, 13);
      else set_len = $urandom_range(12, 1);
      mode = value_mode_t'($urandom_range(2));
      no_idle = (rand_sent >= 120 && rand_sent < 200);
      for (int k = 0; k < set_len; k++) begin
        send_item(pick_value(mode), k == set_len - 1);
        rand_sent++;
      end
      set_count++;
      // after the fifth set, hold off until that set has drained
      if (set_count == 5) begin
        in_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
      end
    end
    no_idle = 1'b0;
    in_tvalid <= 1'b0;

    // drain
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (sb.mismatches == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule
